// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge while reset is released.
`define PIMU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define PIMU_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pimu_pkg.sv -----
package pimu_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int PSC_W          = 16;
	localparam int STORE_W        = 17;

	localparam logic [PSC_W-1:0] PSC_MAX  = 16'hFFFF;
	localparam logic [PSC_W-1:0] PSC_HALF = 16'h7FFF;

	// Next prescaler after an overflow: 0 -> 1, max wraps to 0,
	// upper half saturates to max, otherwise double.
	function automatic logic [PSC_W-1:0] step_prescaler(input logic [PSC_W-1:0] p);
		logic [PSC_W-1:0] r;
		if (p == '0) begin
			r = PSC_W'(1);
		end else if (p == PSC_MAX) begin
			r = '0;
		end else if (p > PSC_HALF) begin
			r = PSC_MAX;
		end else begin
			r = {p[PSC_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// ----- rtl/pimu_evt_if.sv -----
interface pimu_evt_if
	import pimu_pkg::*;
	#(parameter int COUNT_BITS = COUNT_BITS_DEF)
	();

	logic                  valid;
	logic                  ready;
	logic                  restart;
	logic                  overflow;
	logic                  capture;
	logic [COUNT_BITS-1:0] period_capture;
	logic [COUNT_BITS-1:0] high_capture;

	modport source (
		output valid, restart, overflow, capture, period_capture, high_capture,
		input  ready
	);

	modport sink (
		input  valid, restart, overflow, capture, period_capture, high_capture,
		output ready
	);

endinterface

// ----- rtl/pimu_res_if.sv -----
interface pimu_res_if
	import pimu_pkg::*;
	();

	logic               valid;
	logic               ready;
	logic               done_res;
	logic [STORE_W-1:0] high_count;
	logic [STORE_W-1:0] period_count;
	logic [PSC_W-1:0]   prescaler;
	logic               clear_counter;
	logic               stop_timer;

	modport source (
		output valid, done_res, high_count, period_count, prescaler,
			clear_counter, stop_timer,
		input  ready
	);

	modport sink (
		input  valid, done_res, high_count, period_count, prescaler,
			clear_counter, stop_timer,
		output ready
	);

endinterface

// ----- rtl/pwm_input_autorange_measure_unit.sv -----
// Channel  Dir  Word contents
// -------  ---  ---------------------------------------------------------------
// evt      in   restart, overflow, capture, period_capture, high_capture
// res      out  done_res, high_count, period_count, prescaler, clear_counter,
//               stop_timer
//
// One word in, one word out. The event word is held in the input register,
// the flag/prescaler update runs as compares and two short adds, and the
// result lands in the output register.
// A new event word is taken every cycle while res is being drained.
// arst_n clears the flags, the prescaler and the counts to zero.
// A stall on res holds the result; evt keeps taking one word into the input
// register, then drops ready until the output register frees up.
`include "assert_macros.svh"

module pwm_input_autorange_measure_unit
	import pimu_pkg::*;
	#(parameter int COUNT_BITS = COUNT_BITS_DEF)
	(
	input  logic        clk,
	input  logic        arst_n,
	pimu_evt_if.sink    evt,
	pimu_res_if.source  res
	);

	// Width wide enough for capture + 2 and for the stored count.
	localparam int EXT_W = (COUNT_BITS + 2 > STORE_W) ? COUNT_BITS + 2 : STORE_W;

	// Input register
	logic                  valid_s1;
	logic                  restart_s1;
	logic                  overflow_s1;
	logic                  capture_s1;
	logic [COUNT_BITS-1:0] period_s1;
	logic [COUNT_BITS-1:0] high_s1;

	// Measurement state
	logic               done_q;
	logic               armed_q;
	logic [PSC_W-1:0]   psc_q;
	logic [STORE_W-1:0] high_q;
	logic [STORE_W-1:0] period_q;

	// Next state and per-word flags
	logic               done_d;
	logic               armed_d;
	logic [PSC_W-1:0]   psc_d;
	logic [STORE_W-1:0] high_d;
	logic [STORE_W-1:0] period_d;
	logic               clear_d;
	logic               stop_d;

	// Output register
	logic               valid_s2;
	logic               done_s2;
	logic [STORE_W-1:0] high_s2;
	logic [STORE_W-1:0] period_s2;
	logic [PSC_W-1:0]   psc_s2;
	logic               clear_s2;
	logic               stop_s2;

	logic               adv_s1;
	logic               take_evt;
	logic               meas_ok;
	logic               bump;
	logic [EXT_W-1:0]   high_sum;
	logic [EXT_W-1:0]   period_sum;

	// Advance the input word whenever the output register is empty or draining.
	assign adv_s1   = valid_s1 && (!valid_s2 || res.ready);
	assign evt.ready = !valid_s1 || adv_s1;
	assign take_evt = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_evt) begin
			restart_s1  <= evt.restart;
			overflow_s1 <= evt.overflow;
			capture_s1  <= evt.capture;
			period_s1   <= evt.period_capture;
			high_s1     <= evt.high_capture;
		end
	end

	// hv < pv with both +1 is the same compare on the raw captures.
	assign meas_ok    = high_s1 < period_s1;
	// A measurement at prescaler 0 counts one extra tick on each side.
	assign bump       = meas_ok && (psc_q == '0);
	assign high_sum   = EXT_W'(high_s1) + EXT_W'(1) + EXT_W'(bump);
	assign period_sum = EXT_W'(period_s1) + EXT_W'(1) + EXT_W'(bump);

	always_comb begin
		done_d   = done_q;
		armed_d  = armed_q;
		psc_d    = psc_q;
		high_d   = high_q;
		period_d = period_q;
		clear_d  = 1'b0;
		stop_d   = 1'b0;
		if (restart_s1) begin
			// Restart wins over any other event in the same word.
			done_d  = 1'b0;
			psc_d   = '0;
			clear_d = 1'b1;
		end else if (done_q) begin
			// Measurement finished: hold everything until restart.
		end else if (overflow_s1 && !capture_s1) begin
			// Counter ran out before a capture: disarm and widen the range.
			armed_d = 1'b0;
			psc_d   = step_prescaler(psc_q);
			clear_d = 1'b1;
		end else if (!armed_q) begin
			if (capture_s1) begin
				armed_d = 1'b1;
			end
		end else if (capture_s1) begin
			high_d   = high_sum[STORE_W-1:0];
			period_d = period_sum[STORE_W-1:0];
			if (meas_ok) begin
				done_d  = 1'b1;
				armed_d = 1'b0;
				stop_d  = 1'b1;
			end else begin
				// High time not below period: not done; keep the new counts, clear the
				// prescaler and the counter, staying armed.
				done_d  = 1'b0;
				psc_d   = '0;
				clear_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			armed_q  <= 1'b0;
			psc_q    <= '0;
			high_q   <= '0;
			period_q <= '0;
		end else if (adv_s1) begin
			done_q   <= done_d;
			armed_q  <= armed_d;
			psc_q    <= psc_d;
			high_q   <= high_d;
			period_q <= period_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			done_s2   <= done_d;
			high_s2   <= high_d;
			period_s2 <= period_d;
			psc_s2    <= psc_d;
			clear_s2  <= clear_d;
			stop_s2   <= stop_d;
		end
	end

	assign res.valid         = valid_s2;
	assign res.done_res      = done_s2;
	assign res.high_count    = high_s2;
	assign res.period_count  = period_s2;
	assign res.prescaler     = psc_s2;
	assign res.clear_counter = clear_s2;
	assign res.stop_timer    = stop_s2;

	// A completed measurement always reports done and never clears the counter.
	`PIMU_ASSERT(a_stop_done,
		(res.valid && res.stop_timer) |-> (res.done_res && !res.clear_counter),
		"stop_timer without done_res or with clear_counter")
	// Once done, only a restart may change the state.
	`PIMU_ASSERT(a_done_hold,
		(adv_s1 && done_q && !restart_s1) |=>
			(done_q && $stable(psc_q) && $stable(high_q) && $stable(period_q)),
		"state changed while done")
	// An empty output register never blocks the input side.
	`PIMU_ASSERT(a_ready_free, !valid_s2 |-> evt.ready, "evt stalled with empty output register")
	// A restart word always clears the prescaler and requests a counter reset.
	`PIMU_ASSERT_ALWAYS(a_restart_clear,
		(arst_n && adv_s1 && restart_s1) |-> (psc_d == '0 && clear_d && !done_d),
		"restart did not clear")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import pimu_pkg::*;

	localparam int CB         = COUNT_BITS_DEF;
	localparam int STALL_MAX  = 2000;  // cycles with no word moving on either side
	localparam int TAIL_WORDS = 100;   // last part of the run: no idling at all
	localparam int RAND_WORDS = 1150;

	// One event word as the timer hands it over.
	typedef struct packed {
		logic          restart;
		logic          overflow;
		logic          capture;
		logic [CB-1:0] period_capture;
		logic [CB-1:0] high_capture;
	} evt_word_t;

	// One result word as the block reports it.
	typedef struct packed {
		logic               done_res;
		logic [STORE_W-1:0] high_count;
		logic [STORE_W-1:0] period_count;
		logic [PSC_W-1:0]   prescaler;
		logic               clear_counter;
		logic               stop_timer;
	} res_word_t;

	logic clk;
	logic arst_n;

	pimu_evt_if #(.COUNT_BITS(CB)) evt_if ();
	pimu_res_if                    res_if ();

	pwm_input_autorange_measure_unit #(.COUNT_BITS(CB)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_if),
		.res    (res_if)
	);

	// 12 ns period.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Event words waiting for the driver, and results still owed by the block.
	evt_word_t evt_words[$];
	res_word_t owed_results[$];

	int error_count = 0;
	int stall_cycles = 0;
	bit evt_taken = 1'b0;
	int src_gap = 0;
	int snk_gap = 0;

	// Shadow of the measurement state, advanced once per accepted event word.
	logic               m_done   = 1'b0;
	logic               m_armed  = 1'b0;
	logic [PSC_W-1:0]   m_psc    = '0;
	logic [STORE_W-1:0] m_high   = '0;
	logic [STORE_W-1:0] m_period = '0;

	// Auto-range step: 0 starts at 1, the top value wraps to 0, the upper
	// half saturates at the top, everything else doubles.
	function automatic logic [PSC_W-1:0] next_prescale(logic [PSC_W-1:0] p);
		logic [PSC_W-1:0] n;
		if (p == '0) begin
			n = PSC_W'(1);
		end else if (p == {PSC_W{1'b1}}) begin
			n = '0;
		end else if (p[PSC_W-1]) begin
			n = {PSC_W{1'b1}};
		end else begin
			n = p << 1;
		end
		return n;
	endfunction

	// Advance the shadow state by one event word and return what the block
	// must report for it.
	function automatic res_word_t predict_measurement(evt_word_t w);
		res_word_t          r;
		logic [STORE_W-1:0] hv;
		logic [STORE_W-1:0] pv;
		r.clear_counter = 1'b0;
		r.stop_timer    = 1'b0;
		if (w.restart) begin
			// restart wins over anything else in the same word
			m_done = 1'b0;
			m_psc = '0;
			r.clear_counter = 1'b1;
		end else if (m_done) begin
			// measurement finished: ignore every event until a restart
		end else if (w.overflow && !w.capture) begin
			// counter ran out before a full period: disarm and range up
			m_armed = 1'b0;
			m_psc = next_prescale(m_psc);
			r.clear_counter = 1'b1;
		end else if (!m_armed) begin
			// first edge only arms; overflow together with capture counts as capture
			if (w.capture) begin
				m_armed = 1'b1;
			end
		end else if (w.capture) begin
			hv = STORE_W'(w.high_capture) + STORE_W'(1);
			pv = STORE_W'(w.period_capture) + STORE_W'(1);
			if (hv < pv) begin
				m_done = 1'b1;
				// undivided clock: one more tick each
				if (m_psc == '0) begin
					hv = hv + STORE_W'(1);
					pv = pv + STORE_W'(1);
				end
				m_armed = 1'b0;
				r.stop_timer = 1'b1;
			end else begin
				// high time not below period: keep the counts, not done, keep armed, start over
				m_done = 1'b0;
				m_psc = '0;
				r.clear_counter = 1'b1;
			end
			m_high = hv;
			m_period = pv;
		end
		r.done_res     = m_done;
		r.high_count   = m_high;
		r.period_count = m_period;
		r.prescaler    = m_psc;
		return r;
	endfunction

	task automatic queue_word(bit rs, bit ov, bit cp, logic [CB-1:0] pc, logic [CB-1:0] hc);
		evt_word_t w;
		w.restart        = rs;
		w.overflow       = ov;
		w.capture        = cp;
		w.period_capture = pc;
		w.high_capture   = hc;
		evt_words.push_back(w);
	endtask

	function automatic logic [CB-1:0] rnd_count();
		return CB'($urandom_range(0, (1 << CB) - 1));
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Fill the event queue: a short directed part, then random measurement
	// sequences mixed with noise words.
	task automatic build_stimulus();
		int            n_ovf;
		int            n_tail;
		logic [CB-1:0] pc;
		logic [CB-1:0] hc;
		// directed: reset state, arming, extremes, rejection, done, restart
		queue_word(0, 0, 0, '0, '0);                 // no event
		queue_word(0, 1, 1, rnd_count(), rnd_count()); // overflow with capture arms
		queue_word(0, 0, 1, '1, '0);                 // widest accepted reading, no prescaler
		queue_word(0, 1, 1, rnd_count(), rnd_count()); // ignored while done
		queue_word(0, 1, 0, rnd_count(), rnd_count()); // ignored while done
		queue_word(1, 1, 1, '1, '1);                 // restart drops the other events
		queue_word(0, 1, 0, '0, '0);                 // range up 0 -> 1
		queue_word(0, 1, 0, '1, '1);                 // range up 1 -> 2
		queue_word(0, 0, 1, rnd_count(), rnd_count()); // arm
		queue_word(0, 0, 0, rnd_count(), rnd_count()); // armed, no event
		queue_word(0, 0, 1, '1, '1);                 // high equals period: reject
		queue_word(0, 0, 1, CB'(101), CB'(100));     // still armed: accepted at prescaler 0
		queue_word(1, 0, 0, '0, '0);                 // restart
		queue_word(0, 1, 0, rnd_count(), rnd_count()); // range up
		queue_word(0, 0, 1, rnd_count(), rnd_count()); // arm
		queue_word(0, 1, 0, rnd_count(), rnd_count()); // disarm while armed
		queue_word(0, 0, 1, rnd_count(), rnd_count()); // arm again
		queue_word(0, 0, 1, '0, '0);                 // zero counts: reject
		queue_word(0, 0, 1, '1, CB'('1 - 1));        // just below period, prescaler 0
		queue_word(1, 0, 0, '0, '0);
		queue_word(0, 1, 0, '0, '0);
		queue_word(0, 0, 1, '0, '0);                 // arm
		queue_word(0, 0, 1, '1, CB'('1 - 1));        // just below period, prescaler 1
		queue_word(1, 1, 1, rnd_count(), rnd_count());

		while (evt_words.size() < RAND_WORDS) begin
			if ($urandom_range(0, 9) < 7) begin
				// well-formed measurement with random content
				queue_word(1, $urandom_range(0, 1), $urandom_range(0, 1), rnd_count(),
					rnd_count());
				// mostly short range-ups, sometimes long enough to saturate and wrap
				n_ovf = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 20)
					: $urandom_range(0, 4);
				repeat (n_ovf) queue_word(0, 1, 0, rnd_count(), rnd_count());
				queue_word(0, $urandom_range(0, 1), 1, rnd_count(), rnd_count());
				if ($urandom_range(0, 3) == 0) begin
					queue_word(0, 0, 0, rnd_count(), rnd_count());
				end
				if ($urandom_range(0, 4) != 0) begin
					pc = CB'($urandom_range(1, (1 << CB) - 1));
					hc = CB'($urandom_range(0, pc - 1));
				end else begin
					hc = rnd_count();
					pc = CB'($urandom_range(0, hc));
				end
				queue_word(0, $urandom_range(0, 1), 1, pc, hc);
				n_tail = $urandom_range(0, 2);
				repeat (n_tail) queue_word(0, $urandom_range(0, 1), $urandom_range(0, 1),
					rnd_count(), rnd_count());
			end else begin
				// noise word, restart now and then
				queue_word($urandom_range(0, 3) == 0, $urandom_range(0, 1),
					$urandom_range(0, 1), rnd_count(), rnd_count());
			end
		end
	endtask

	// Driver: present the next event word at the falling edge once the
	// previous one was taken; insert idle bursts except near the end.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!evt_if.valid || evt_taken) begin
				if (src_gap > 0) begin
					evt_if.valid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (evt_words.size() > TAIL_WORDS && $urandom_range(0, 9) == 0) begin
					evt_if.valid <= 1'b0;
					src_gap <= $urandom_range(0, 5);
				end else if (evt_words.size() > 0) begin
					evt_if.restart        <= evt_words[0].restart;
					evt_if.overflow       <= evt_words[0].overflow;
					evt_if.capture        <= evt_words[0].capture;
					evt_if.period_capture <= evt_words[0].period_capture;
					evt_if.high_capture   <= evt_words[0].high_capture;
					evt_if.valid <= 1'b1;
					void'(evt_words.pop_front());
				end else begin
					evt_if.valid <= 1'b0;
				end
			end

			// Result side: stall in bursts, never in the last part.
			if (snk_gap > 0) begin
				res_if.ready <= 1'b0;
				snk_gap <= snk_gap - 1;
			end else if (evt_words.size() > TAIL_WORDS && $urandom_range(0, 9) == 0) begin
				res_if.ready <= 1'b0;
				snk_gap <= $urandom_range(0, 5);
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Monitor: at the rising edge, predict for each accepted event word and
	// compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin
		evt_word_t ew;
		res_word_t want;
		evt_taken <= evt_if.valid && evt_if.ready;
		if (arst_n) begin
			if (evt_if.valid && evt_if.ready) begin
				ew.restart        = evt_if.restart;
				ew.overflow       = evt_if.overflow;
				ew.capture        = evt_if.capture;
				ew.period_capture = evt_if.period_capture;
				ew.high_capture   = evt_if.high_capture;
				owed_results.push_back(predict_measurement(ew));
			end
			if (res_if.valid && res_if.ready) begin
				if (owed_results.size() == 0) begin
					$error("result word with no event word pending");
					error_count++;
				end else begin
					want = owed_results.pop_front();
					check_field("done_res", want.done_res, res_if.done_res);
					check_field("high_count", want.high_count, res_if.high_count);
					check_field("period_count", want.period_count, res_if.period_count);
					check_field("prescaler", want.prescaler, res_if.prescaler);
					check_field("clear_counter", want.clear_counter, res_if.clear_counter);
					check_field("stop_timer", want.stop_timer, res_if.stop_timer);
				end
			end

			// Watchdog: give up when no word moves for too long.
			if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= STALL_MAX) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		evt_if.valid = 1'b0;
		evt_if.restart = 1'b0;
		evt_if.overflow = 1'b0;
		evt_if.capture = 1'b0;
		evt_if.period_capture = '0;
		evt_if.high_capture = '0;
		res_if.ready = 1'b0;
		build_stimulus();

		// hold reset, then release it away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain the event queue, then every owed result, then let the pipe settle
		@(posedge clk);
		while (evt_words.size() != 0 || evt_if.valid) @(posedge clk);
		while (owed_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pimu_pkg.sv
rtl/pimu_evt_if.sv
rtl/pimu_res_if.sv
rtl/pwm_input_autorange_measure_unit.sv
bench/testbench.sv
